[rtl/core/ntd_pkg.sv]
// shared types, codes and constants of the note code tone decoder
`timescale 1ns / 1ps

package ntd_pkg;

  // result action codes
  localparam logic [2:0] ACT_TONE       = 3'd0;
  localparam logic [2:0] ACT_FULL_REST  = 3'd1;
  localparam logic [2:0] ACT_SHORT_REST = 3'd2;
  localparam logic [2:0] ACT_IGNORED    = 3'd3;
  localparam logic [2:0] ACT_END        = 3'd4;

  // register indexes, byte address is 4 * index
  localparam logic [2:0] REG_PWM_PERIOD  = 3'd0;
  localparam logic [2:0] REG_VOLUME      = 3'd1;
  localparam logic [2:0] REG_VOLUME_MAX  = 3'd2;
  localparam logic [2:0] REG_REF_TIME    = 3'd3;
  localparam logic [2:0] REG_PITCH_MULT  = 3'd4;
  localparam logic [2:0] REG_FREQ_OFFSET = 3'd5;
  localparam logic [2:0] REG_PRESCALE    = 3'd6;

  // melody byte codes
  localparam logic [7:0] CODE_FULL_REST  = 8'd0;
  localparam logic [7:0] CODE_SHORT_LO   = 8'd109;
  localparam logic [7:0] CODE_IGNORED_LO = 8'd120;
  localparam logic [7:0] CODE_END        = 8'd255;
  localparam logic [7:0] CODE_SHORT_BASE = 8'd108;

  // divider geometry
  localparam int QW     = 32;  // quotient bits, one per cell
  localparam int DEN_W  = 59;  // 42 bit frequency times 17 bit prescale
  localparam int FREQ_W = 42;  // Q.19 frequency
  localparam int PROD_W = 33;  // Q8.8 multiplier times Q9.8 pitch

  localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1) << 19;

  // one row moving down the divider chain
  typedef struct packed {
    logic             valid;
    logic [2:0]       action;
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QW-1:0]    nq;    // numerator bits shift out the top, quotient bits in the bottom
  } div_row_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] reload;
    logic [15:0] duty;
    logic [31:0] dur;
    logic        last;
  } res_t;

  // octave 4 base pitches in Q9.8 Hz, order c d e f g a b c# d# f# g# a#
  function automatic logic [16:0] base_pitch(input logic [3:0] cls);
    logic [16:0] p;
    case (cls)
      4'd0:    p = 17'd66977;
      4'd1:    p = 17'd75177;
      4'd2:    p = 17'd84385;
      4'd3:    p = 17'd89403;
      4'd4:    p = 17'd100352;
      4'd5:    p = 17'd112640;
      4'd6:    p = 17'd126433;
      4'd7:    p = 17'd70958;
      4'd8:    p = 17'd79649;
      4'd9:    p = 17'd94717;
      4'd10:   p = 17'd106317;
      4'd11:   p = 17'd119337;
      default: p = 17'd0;
    endcase
    return p;
  endfunction

endpackage

[rtl/core/ntd_div_cell.sv]
// one restoring divider cell: resolves one quotient bit per row
`timescale 1ns / 1ps

module ntd_div_cell
  import ntd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  div_row_t row_in,
  output div_row_t row_out
);

  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;
  div_row_t         row_next;

  always_comb begin
    trial = {row_in.rem, row_in.nq[QW-1]};
    ge    = trial >= {1'b0, row_in.den};
    diff  = trial - {1'b0, row_in.den};
    row_next        = row_in;
    row_next.rem    = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    row_next.nq     = {row_in.nq[QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_out.valid <= 1'b0;
    end else if (en) begin
      row_out.valid <= row_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_out.action <= row_next.action;
      row_out.den    <= row_next.den;
      row_out.rem    <= row_next.rem;
      row_out.nq     <= row_next.nq;
    end
  end

endmodule

[rtl/core/ntd_front.sv]
// front end: decodes the melody byte and builds the divider operands
`timescale 1ns / 1ps

module ntd_front
  import ntd_pkg::*;
#(
  parameter int CLOCK_HZ = 120000000
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               note_valid,
  input  logic [7:0]         note_code,
  input  logic [31:0]        reference_time_us,
  input  logic [15:0]        pitch_scale,
  input  logic signed [23:0] freq_offset,
  input  logic [16:0]        tone_prescale,
  output div_row_t           row_out
);

  localparam logic [63:0] NUM = 64'(CLOCK_HZ) << 19;

  // stage a: decode
  logic [7:0]  x;
  logic [15:0] x_recip;
  logic [3:0]  oct_w;
  logic [7:0]  cls_w;
  logic [7:0]  sdiv_w;
  logic [2:0]  kind_w;

  logic        a_valid;
  logic [2:0]  a_action;
  logic [3:0]  a_oct;
  logic [3:0]  a_cls;
  logic [3:0]  a_sdiv;

  // stage b: pitch product
  logic              b_valid;
  logic [2:0]        b_action;
  logic [3:0]        b_oct;
  logic [3:0]        b_sdiv;
  logic [PROD_W-1:0] b_prod;

  // stage c: frequency
  logic              c_valid;
  logic [2:0]        c_action;
  logic [3:0]        c_sdiv;
  logic [FREQ_W-1:0] c_freq;

  logic [40:0]        shifted;
  logic signed [42:0] off_ext;
  logic signed [42:0] freq_sum;
  logic [FREQ_W-1:0]  freq_next;

  logic [16:0]      pre;
  logic [DEN_W-1:0] den_tone;
  div_row_t         row_next;

  always_comb begin
    x       = note_code - 8'd1;
    x_recip = 16'(x) * 16'd171;       // floor(x / 12) for x below 108
    oct_w   = x_recip[14:11];
    cls_w   = x - (8'({oct_w, 3'b000}) + 8'({oct_w, 2'b00}));
    sdiv_w  = note_code - CODE_SHORT_BASE;
    if (note_code == CODE_END) begin
      kind_w = ACT_END;
    end else if (note_code == CODE_FULL_REST) begin
      kind_w = ACT_FULL_REST;
    end else if (note_code < CODE_SHORT_LO) begin
      kind_w = ACT_TONE;
    end else if (note_code < CODE_IGNORED_LO) begin
      kind_w = ACT_SHORT_REST;
    end else begin
      kind_w = ACT_IGNORED;
    end
  end

  // q.19 frequency, clamped to at least 1 hz
  always_comb begin
    shifted  = 41'(b_prod) << b_oct;
    off_ext  = 43'(freq_offset);
    freq_sum = $signed({2'b00, shifted}) + (off_ext <<< 11);
    if (freq_sum <= $signed(43'(FREQ_ONE))) begin
      freq_next = FREQ_ONE;
    end else begin
      freq_next = freq_sum[FREQ_W-1:0];
    end
  end

  always_comb begin
    pre      = (tone_prescale == 17'd0) ? 17'd1 : tone_prescale;
    den_tone = DEN_W'(c_freq) * DEN_W'(pre);
    row_next.valid  = c_valid;
    row_next.action = c_action;
    case (c_action)
      ACT_TONE: begin
        row_next.den = den_tone;
        row_next.rem = DEN_W'(NUM[63:32]);
        row_next.nq  = NUM[31:0];
      end
      ACT_SHORT_REST: begin
        row_next.den = DEN_W'(c_sdiv);
        row_next.rem = '0;
        row_next.nq  = reference_time_us;
      end
      default: begin
        row_next.den = DEN_W'(1);
        row_next.rem = '0;
        row_next.nq  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      b_valid       <= 1'b0;
      c_valid       <= 1'b0;
      row_out.valid <= 1'b0;
    end else if (en) begin
      a_valid       <= note_valid;
      b_valid       <= a_valid;
      c_valid       <= b_valid;
      row_out.valid <= row_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_action <= kind_w;
      a_oct    <= oct_w;
      a_cls    <= cls_w[3:0];
      a_sdiv   <= sdiv_w[3:0];

      b_action <= a_action;
      b_oct    <= a_oct;
      b_sdiv   <= a_sdiv;
      b_prod   <= PROD_W'(pitch_scale) * PROD_W'(base_pitch(a_cls));

      c_action <= b_action;
      c_sdiv   <= b_sdiv;
      c_freq   <= freq_next;

      row_out.action <= row_next.action;
      row_out.den    <= row_next.den;
      row_out.rem    <= row_next.rem;
      row_out.nq     <= row_next.nq;
    end
  end

endmodule

[rtl/core/note_code_tone_decoder_core.sv]
// top level of the note code tone decoder: registers, divider chain, output buffer
`timescale 1ns / 1ps

// Decodes one melody byte per beat into a tone timer reload, a pwm duty
// count and a duration. A new beat is taken every cycle while note_stall
// is low; each beat passes 4 front stages, 32 divider cells and 1 output
// register before its result is shown. The divider chain, one cell per
// quotient bit, serves both the tone reload
// (CLOCK_HZ * 2^19 / (freq * prescale), minus one) and the short rest duration
// (reference_time_us / (code - 108)). A two-entry output buffer lets the
// block keep accepting while a result waits; note_stall rises only once
// both entries hold results. Registers sit at byte addresses 4 * index and
// must only be written while no beat is in flight.

module note_code_tone_decoder_core
  import ntd_pkg::*;
#(
  parameter int CLOCK_HZ = 120000000
) (
  input  logic        clk,
  input  logic        rst,

  // apb register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,

  // melody byte beats
  input  logic        note_valid,
  output logic        note_stall,
  input  logic [7:0]  note_code,

  // result beats
  output logic        result_valid,
  input  logic        result_stall,
  output logic [2:0]  action,
  output logic [31:0] tone_reload,
  output logic [15:0] duty_count,
  output logic [31:0] duration_us,
  output logic        last
);

  // configuration registers
  logic [15:0]        pwm_period_count;
  logic [15:0]        volume;
  logic [15:0]        volume_max;
  logic [31:0]        reference_time_us;
  logic [15:0]        pitch_scale;
  logic signed [23:0] freq_offset;
  logic [16:0]        tone_prescale;

  logic       wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr      = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_period_count  <= 16'd7199;
      volume            <= 16'd0;
      volume_max        <= 16'd32768;
      reference_time_us <= 32'd0;
      pitch_scale       <= 16'd256;
      freq_offset       <= 24'sd0;
      tone_prescale     <= 17'd1;
    end else if (wr) begin
      case (reg_idx)
        REG_PWM_PERIOD:  pwm_period_count  <= pwdata[15:0];
        REG_VOLUME:      volume            <= pwdata[15:0];
        REG_VOLUME_MAX:  volume_max        <= pwdata[15:0];
        REG_REF_TIME:    reference_time_us <= pwdata;
        REG_PITCH_MULT:  pitch_scale       <= pwdata[15:0];
        REG_FREQ_OFFSET: freq_offset       <= pwdata[23:0];
        REG_PRESCALE:    tone_prescale     <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PWM_PERIOD:  prdata = 32'(pwm_period_count);
      REG_VOLUME:      prdata = 32'(volume);
      REG_VOLUME_MAX:  prdata = 32'(volume_max);
      REG_REF_TIME:    prdata = reference_time_us;
      REG_PITCH_MULT:  prdata = 32'(pitch_scale);
      REG_FREQ_OFFSET: prdata = {8'd0, freq_offset};
      REG_PRESCALE:    prdata = 32'(tone_prescale);
      default:         prdata = 32'd0;
    endcase
  end

  // volume duty only moves with the registers, so it is kept up to date
  // continuously instead of riding along with each beat
  logic [15:0] vol_min;
  logic [31:0] duty_prod;
  logic [15:0] duty_q;

  assign vol_min = (volume < volume_max) ? volume : volume_max;

  always_ff @(posedge clk) begin
    duty_prod <= 32'(vol_min) * 32'(pwm_period_count);
    duty_q    <= duty_prod[31:16];
  end

  // the whole chain advances unless the output buffer is full
  logic skid_full;
  logic adv;

  assign adv        = !skid_full;
  assign note_stall = skid_full;

  div_row_t link [0:QW];

  ntd_front #(
    .CLOCK_HZ(CLOCK_HZ)
  ) u_front (
    .clk              (clk),
    .rst              (rst),
    .en               (adv),
    .note_valid       (note_valid),
    .note_code        (note_code),
    .reference_time_us(reference_time_us),
    .pitch_scale      (pitch_scale),
    .freq_offset      (freq_offset),
    .tone_prescale    (tone_prescale),
    .row_out          (link[0])
  );

  // one cell per quotient bit, msb first
  for (genvar i = 0; i < QW; i++) begin : g_cell
    ntd_div_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .row_in (link[i]),
      .row_out(link[i+1])
    );
  end

  // shape the finished row into a result
  logic [QW-1:0] quo;
  res_t          pipe_res;

  assign quo = link[QW].nq;

  always_comb begin
    pipe_res.action = link[QW].action;
    pipe_res.reload = 32'd0;
    pipe_res.duty   = 16'd0;
    pipe_res.dur    = 32'd0;
    pipe_res.last   = 1'b0;
    case (link[QW].action)
      ACT_TONE: begin
        pipe_res.reload = (quo == '0) ? 32'd0 : quo - 32'd1;
        pipe_res.duty   = duty_q;
        pipe_res.dur    = reference_time_us;
      end
      ACT_FULL_REST: begin
        pipe_res.dur = reference_time_us;
      end
      ACT_SHORT_REST: begin
        pipe_res.dur = quo;
      end
      ACT_IGNORED: begin
        pipe_res.duty = duty_q;
      end
      ACT_END: begin
        pipe_res.last = 1'b1;
      end
      default: ;
    endcase
  end

  // output register plus one skid entry
  logic pipe_valid;
  res_t out_q;
  res_t skid_q;
  logic out_free;

  assign pipe_valid = link[QW].valid;
  assign out_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (skid_full) begin
      if (!result_stall) begin
        skid_full <= 1'b0;
      end
    end else if (out_free) begin
      result_valid <= pipe_valid;
    end else if (pipe_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (!result_stall) begin
        out_q <= skid_q;
      end
    end else if (out_free) begin
      out_q <= pipe_res;
    end else begin
      skid_q <= pipe_res;
    end
  end

  assign action      = out_q.action;
  assign tone_reload = out_q.reload;
  assign duty_count  = out_q.duty;
  assign duration_us = out_q.dur;
  assign last        = out_q.last;

endmodule
